>>> src/tmse_pkg.sv
// Shared types and constants of the Turing machine step engine.
`timescale 1ns / 1ps
`default_nettype none

package tmse_pkg;

	// Operation codes of an input item
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_STEP  = 2'd3;

	// Head move codes; code three acts as stay
	localparam logic [1:0] MV_STAY  = 2'd0;
	localparam logic [1:0] MV_RIGHT = 2'd1;
	localparam logic [1:0] MV_LEFT  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd0;
	localparam logic [1:0] CFG_HALT_STATE   = 2'd1;
	localparam logic [1:0] CFG_HEAD_START   = 2'd2;

	// Configuration reset values
	localparam logic [4:0] SYMBOL_COUNT_RST = 5'd16;
	localparam logic [5:0] HALT_STATE_RST   = 6'd63;
	localparam logic [9:0] HEAD_START_RST   = 10'd1;

	// Blank tape symbol '-'
	localparam logic [7:0] BLANK_SYM = 8'h2D;

	// Reported status when a transition load completes
	localparam logic [2:0] ST_LOADED = 3'd4;

	// Latched run status
	typedef enum logic [1:0] {
		RS_RUN  = 2'd0,
		RS_HALT = 2'd1,
		RS_FAIL = 2'd2,
		RS_OFF  = 2'd3
	} run_t;

	// Datapath action; each one but ACT_NONE also produces the result
	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_LOAD   = 3'd1,
		ACT_TWRITE = 3'd2,
		ACT_TREAD  = 3'd3,
		ACT_STOP   = 3'd4,
		ACT_FAIL   = 3'd5,
		ACT_COMMIT = 3'd6
	} act_t;

	// One transition table entry
	typedef struct packed {
		logic [1:0] move;
		logic [5:0] target_state;
		logic [7:0] new_symbol;
		logic [7:0] match_symbol;
	} entry_t;

	// Input item
	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] state_index;
		logic [3:0] slot_index;
		logic [7:0] match_symbol;
		logic [7:0] new_symbol;
		logic [5:0] target_state;
		logic [1:0] move;
		logic [9:0] tape_address;
		logic [7:0] tape_symbol;
	} item_t;

	// Result item
	typedef struct packed {
		logic [5:0] current_state;
		logic [9:0] head_position;
		logic [7:0] cell_symbol;
		logic [2:0] status;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic clr_run;
		logic rd_item;
		logic rd_head;
		logic srch_init;
		logic srch_run;
		logic cur_ld;
		act_t act;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       pre_stop;
		logic       hit;
		logic       exhausted;
		logic       clr_last;
	} stat_t;

endpackage

`default_nettype wire

>>> src/tmse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tmse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/tmse_ctrl.sv
// Controller state machine sequencing items through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module tmse_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire tmse_pkg::stat_t stat,
	output tmse_pkg::cmd_t       cmd
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_READ   = 7'b0001000,
		S_FETCH  = 7'b0010000,
		S_SEARCH = 7'b0100000,
		S_COMMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.act = tmse_pkg::ACT_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op)
					tmse_pkg::OP_LOAD: begin
						cmd.act = tmse_pkg::ACT_LOAD;
						state_d = S_IDLE;
					end
					tmse_pkg::OP_WRITE: begin
						cmd.act = tmse_pkg::ACT_TWRITE;
						state_d = S_IDLE;
					end
					tmse_pkg::OP_READ: begin
						cmd.rd_item = 1'b1;
						state_d = S_READ;
					end
					tmse_pkg::OP_STEP: begin
						if (stat.pre_stop) begin
							cmd.act = tmse_pkg::ACT_STOP;
							state_d = S_IDLE;
						end else begin
							cmd.rd_head = 1'b1;
							cmd.srch_init = 1'b1;
							state_d = S_FETCH;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_READ: begin
				cmd.act = tmse_pkg::ACT_TREAD;
				state_d = S_IDLE;
			end
			S_FETCH: begin
				// tape cell under head arrives; slot 0 is fetched
				cmd.cur_ld = 1'b1;
				cmd.srch_run = 1'b1;
				state_d = S_SEARCH;
			end
			S_SEARCH: begin
				cmd.srch_run = 1'b1;
				if (stat.hit) begin
					state_d = S_COMMIT;
				end else if (stat.exhausted) begin
					cmd.act = tmse_pkg::ACT_FAIL;
					state_d = S_IDLE;
				end
			end
			S_COMMIT: begin
				cmd.act = tmse_pkg::ACT_COMMIT;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/tmse_dp.sv
// Datapath: configuration, machine registers, table and tape memories, slot search.
`timescale 1ns / 1ps
`default_nettype none

module tmse_dp #(
	parameter int STATE_COUNT     = 64,
	parameter int SLOTS_PER_STATE = 16,
	parameter int TAPE_CELLS      = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmse_pkg::cmd_t    cmd,
	output tmse_pkg::stat_t        stat,
	input  wire tmse_pkg::item_t   item,
	output tmse_pkg::result_t      result,
	output logic                   done,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [9:0]        cfg_data
);

	// Only the first 1024 cells are reachable by a 10-bit address or head
	localparam int TAPE_DEPTH = (TAPE_CELLS < 1024) ? TAPE_CELLS : 1024;
	localparam int TAW        = $clog2(TAPE_DEPTH);
	localparam int TBL_DEPTH  = STATE_COUNT * SLOTS_PER_STATE;
	localparam int TBW        = $clog2(TBL_DEPTH);
	localparam int SIW        = $clog2(SLOTS_PER_STATE + 1);

	// Configuration and machine registers
	logic [4:0]     sym_count_q;
	logic [5:0]     final_q;
	logic [5:0]     state_q;
	logic [9:0]     head_q;
	tmse_pkg::run_t run_q;
	logic [TAW-1:0] clr_q;
	logic [SIW-1:0] idx_q;
	logic           pend_s1;
	logic           done_q;

	// Payload registers
	tmse_pkg::item_t   item_q;
	logic [7:0]        cur_q;
	tmse_pkg::entry_t  entry_q;
	tmse_pkg::result_t result_q;

	// Memory ports
	logic                  tbl_we, tbl_re;
	logic [TBW-1:0]        tbl_waddr, tbl_raddr;
	tmse_pkg::entry_t      tbl_wdata, tbl_rdata;
	logic                  tape_we, tape_re;
	logic [TAW-1:0]        tape_waddr, tape_raddr;
	logic [7:0]            tape_wdata, tape_rdata;

	// Decoded conditions
	logic [31:0]    load_sum, srch_sum;
	logic           load_ok, addr_ok, state_ok, head_out, match;
	logic [7:0]     lim;
	logic           issue;
	tmse_pkg::run_t vis_run, stop_run, commit_run;
	logic [9:0]     commit_head;
	logic           right_off, left_off, off;

	// Item range checks and table addresses
	assign load_sum = 32'(item_q.state_index) * 32'(SLOTS_PER_STATE) + 32'(item_q.slot_index);
	assign srch_sum = 32'(state_q) * 32'(SLOTS_PER_STATE) + 32'(idx_q);
	assign load_ok  = (32'(item_q.state_index) < 32'(STATE_COUNT))
		&& (32'(item_q.slot_index) < 32'(SLOTS_PER_STATE));
	assign addr_ok  = (32'(item_q.tape_address) < 32'(TAPE_DEPTH));
	assign state_ok = (32'(state_q) < 32'(STATE_COUNT));
	assign head_out = (11'(head_q) >= 11'(TAPE_DEPTH));

	// Slots searched: min(symbol_count, slots), none for a state outside the table
	always_comb begin
		if (!state_ok) begin
			lim = 8'd0;
		end else if (8'(sym_count_q) >= 8'(SLOTS_PER_STATE)) begin
			lim = 8'(SLOTS_PER_STATE);
		end else begin
			lim = 8'(sym_count_q);
		end
	end

	assign issue = cmd.srch_run && (8'(idx_q) < lim);
	assign match = pend_s1 && (tbl_rdata.match_symbol == cur_q);

	// Status visible to other items, and latched status of a step that does nothing
	always_comb begin
		if (run_q != tmse_pkg::RS_RUN) begin
			vis_run  = run_q;
			stop_run = run_q;
		end else if (state_q == final_q) begin
			vis_run  = tmse_pkg::RS_HALT;
			stop_run = tmse_pkg::RS_HALT;
		end else begin
			vis_run  = tmse_pkg::RS_RUN;
			stop_run = tmse_pkg::RS_OFF;
		end
	end

	// Head move of a committed step
	assign right_off = ((11'(head_q) + 11'd1) >= 11'(TAPE_DEPTH));
	assign left_off  = (head_q == 10'd0);
	always_comb begin
		off = 1'b0;
		commit_head = head_q;
		case (entry_q.move)
			tmse_pkg::MV_RIGHT: begin
				off = right_off;
				if (!right_off) begin
					commit_head = head_q + 10'd1;
				end
			end
			tmse_pkg::MV_LEFT: begin
				off = left_off;
				if (!left_off) begin
					commit_head = head_q - 10'd1;
				end
			end
			default: begin
				commit_head = head_q;
			end
		endcase
		if (off) begin
			commit_run = tmse_pkg::RS_OFF;
		end else if (entry_q.target_state == final_q) begin
			commit_run = tmse_pkg::RS_HALT;
		end else begin
			commit_run = tmse_pkg::RS_RUN;
		end
	end

	// Transition table port controls
	assign tbl_we    = (cmd.act == tmse_pkg::ACT_LOAD) && load_ok;
	assign tbl_waddr = load_sum[TBW-1:0];
	assign tbl_wdata = '{move: item_q.move, target_state: item_q.target_state,
		new_symbol: item_q.new_symbol, match_symbol: item_q.match_symbol};
	assign tbl_re    = issue;
	assign tbl_raddr = srch_sum[TBW-1:0];

	// Tape port controls: clearing sweep, item write, step write
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = clr_q;
		tape_wdata = tmse_pkg::BLANK_SYM;
		if (cmd.clr_run) begin
			tape_we = 1'b1;
		end else if ((cmd.act == tmse_pkg::ACT_TWRITE) && addr_ok) begin
			tape_we    = 1'b1;
			tape_waddr = item_q.tape_address[TAW-1:0];
			tape_wdata = item_q.tape_symbol;
		end else if (cmd.act == tmse_pkg::ACT_COMMIT) begin
			tape_we    = 1'b1;
			tape_waddr = head_q[TAW-1:0];
			tape_wdata = entry_q.new_symbol;
		end
	end
	assign tape_re    = cmd.rd_item || cmd.rd_head;
	assign tape_raddr = cmd.rd_head ? head_q[TAW-1:0] : item_q.tape_address[TAW-1:0];

	tmse_ram #(
		.WIDTH($bits(tmse_pkg::entry_t)),
		.DEPTH(TBL_DEPTH)
	) u_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	tmse_ram #(
		.WIDTH(8),
		.DEPTH(TAPE_DEPTH)
	) u_tape (
		.clk  (clk),
		.we   (tape_we),
		.waddr(tape_waddr),
		.wdata(tape_wdata),
		.re   (tape_re),
		.raddr(tape_raddr),
		.rdata(tape_rdata)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= tmse_pkg::SYMBOL_COUNT_RST;
			final_q     <= tmse_pkg::HALT_STATE_RST;
			state_q     <= 6'd0;
			head_q      <= tmse_pkg::HEAD_START_RST;
			run_q       <= tmse_pkg::RS_RUN;
			clr_q       <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (cmd.act != tmse_pkg::ACT_NONE);
			if (cmd.clr_run) begin
				clr_q <= clr_q + 1'b1;
			end
			// slot search: one table read issued per cycle, compared in the next cycle
			if (cmd.srch_init) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			case (cmd.act)
				tmse_pkg::ACT_STOP: begin
					run_q <= stop_run;
				end
				tmse_pkg::ACT_FAIL: begin
					run_q <= tmse_pkg::RS_FAIL;
				end
				tmse_pkg::ACT_COMMIT: begin
					run_q   <= commit_run;
					state_q <= entry_q.target_state;
					head_q  <= commit_head;
				end
				default: begin
					run_q <= run_q;
				end
			endcase
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					tmse_pkg::CFG_SYMBOL_COUNT: sym_count_q <= cfg_data[4:0];
					tmse_pkg::CFG_HALT_STATE:   final_q     <= cfg_data[5:0];
					tmse_pkg::CFG_HEAD_START:   head_q      <= cfg_data;
					default:                    sym_count_q <= sym_count_q;
				endcase
			end
		end
	end

	// Payload registers and result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.cur_ld) begin
			cur_q <= tape_rdata;
		end
		if (cmd.srch_run && match) begin
			entry_q <= tbl_rdata;
		end
		case (cmd.act)
			tmse_pkg::ACT_LOAD: begin
				result_q <= '{current_state: state_q, head_position: head_q,
					cell_symbol: 8'd0, status: tmse_pkg::ST_LOADED};
			end
			tmse_pkg::ACT_TWRITE: begin
				result_q <= '{current_state: state_q, head_position: head_q,
					cell_symbol: 8'd0, status: {1'b0, vis_run}};
			end
			tmse_pkg::ACT_TREAD: begin
				result_q <= '{current_state: state_q, head_position: head_q,
					cell_symbol: addr_ok ? tape_rdata : tmse_pkg::BLANK_SYM,
					status: {1'b0, vis_run}};
			end
			tmse_pkg::ACT_STOP: begin
				result_q <= '{current_state: state_q, head_position: head_q,
					cell_symbol: 8'd0, status: {1'b0, stop_run}};
			end
			tmse_pkg::ACT_FAIL: begin
				result_q <= '{current_state: state_q, head_position: head_q,
					cell_symbol: 8'd0, status: {1'b0, tmse_pkg::RS_FAIL}};
			end
			tmse_pkg::ACT_COMMIT: begin
				result_q <= '{current_state: entry_q.target_state, head_position: commit_head,
					cell_symbol: entry_q.new_symbol, status: {1'b0, commit_run}};
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	// Status to the controller
	assign stat.op        = item_q.operation;
	assign stat.pre_stop  = (run_q != tmse_pkg::RS_RUN) || (state_q == final_q) || head_out;
	assign stat.hit       = match;
	assign stat.exhausted = (8'(idx_q) >= lim);
	assign stat.clr_last  = (clr_q == TAW'(TAPE_DEPTH - 1));

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

>>> src/turing_machine_step_engine.sv
// Top level of the single-tape Turing machine step engine.
//
//  channel  | ports                                  | transfer when
//  ---------+----------------------------------------+-----------------------
//  item     | start, busy, item                      | start high, busy low
//  result   | done, result                           | done high (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready
//
// After reset the tape is swept to blank, one cell a cycle, with busy high;
// configuration writes are taken during the sweep.
// Busy stays high from a transfer until its result; a step searches its slots
// with one table read per slot, until a slot matches or the searched slots run out.
// The result strobe is high in the first cycle with busy low; it cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module turing_machine_step_engine #(
	parameter int STATE_COUNT     = 64,
	parameter int SLOTS_PER_STATE = 16,
	parameter int TAPE_CELLS      = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire tmse_pkg::item_t   item,
	output logic                   done,
	output tmse_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [9:0]        cfg_data
);

	tmse_pkg::cmd_t  cmd;
	tmse_pkg::stat_t stat;

	// Registers are writable in every cycle
	assign cfg_ready = 1'b1;

	tmse_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	tmse_dp #(
		.STATE_COUNT    (STATE_COUNT),
		.SLOTS_PER_STATE(SLOTS_PER_STATE),
		.TAPE_CELLS     (TAPE_CELLS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.item     (item),
		.result   (result),
		.done     (done),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule

`default_nettype wire

>>> sim/turing_machine_step_engine_test.sv
// Self-checking testbench of the Turing machine step engine: directed and random items.
`timescale 1ns / 1ps

module turing_machine_step_engine_test;

	localparam int TABLE_DEPTH   = 1024;
	localparam int TAPE_DEPTH    = 1024;
	localparam int SLOTS         = 16;
	localparam int STALL_LIMIT   = 5000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int TAIL_CYCLES   = 40;

	// Index with no register behind it; writes there change nothing
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	// Move code three, acts as stay
	localparam logic [1:0] MV_HOLD = 2'd3;

	// Symbols of the small alphabet most programs use
	localparam logic [7:0] SYM_GT   = 8'h3E;
	localparam logic [7:0] SYM_LT   = 8'h3C;
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_ONE  = 8'h31;

	typedef struct {
		logic [1:0] index;
		logic [9:0] data;
	} reg_write_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	tmse_pkg::item_t   item      = '0;
	logic              cfg_valid = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [9:0]        cfg_data  = '0;
	logic              busy;
	logic              done;
	logic              cfg_ready;
	tmse_pkg::result_t result;

	// Machine copy kept by the predictor
	tmse_pkg::entry_t rule_table [TABLE_DEPTH];
	bit               rule_loaded [TABLE_DEPTH];
	logic [7:0]       tape [TAPE_DEPTH];
	logic [5:0]       machine_state;
	logic [9:0]       head_pos;
	tmse_pkg::run_t   run_state;
	logic [4:0]       symbol_count;
	logic [5:0]       halt_state;
	logic [9:0]       head_start;

	tmse_pkg::result_t expected_results [$];
	reg_write_t        reg_writes [$];
	int                errors       = 0;
	int                stall_cycles = 0;
	int                items_sent   = 0;
	bit                idle_on;
	int                idle_pct;

	turing_machine_step_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic int search_width();
		return (symbol_count < SLOTS) ? int'(symbol_count) : SLOTS;
	endfunction

	// First slot of the current state matching the cell under the head, -1 if none.
	// gap_slot: first never-loaded slot met before the hit, -1 if none.
	function automatic int find_rule(output int gap_slot);
		int hit;
		logic [7:0] cur;
		hit = -1;
		gap_slot = -1;
		cur = tape[head_pos];
		for (int i = 0; i < search_width() && hit < 0; i++) begin
			if (!rule_loaded[machine_state * SLOTS + i]) begin
				if (gap_slot < 0)
					gap_slot = i;
			end else if (rule_table[machine_state * SLOTS + i].match_symbol == cur) begin
				hit = i;
			end
		end
		return hit;
	endfunction

	function automatic logic [2:0] shown_status();
		if (run_state != tmse_pkg::RS_RUN)
			return {1'b0, run_state};
		return (machine_state == halt_state) ? {1'b0, tmse_pkg::RS_HALT}
			: {1'b0, tmse_pkg::RS_RUN};
	endfunction

	function automatic bit leaves_tape(logic [1:0] mv);
		return (mv == tmse_pkg::MV_RIGHT && head_pos == 10'(TAPE_DEPTH - 1)) ||
			(mv == tmse_pkg::MV_LEFT && head_pos == 10'd0);
	endfunction

	// Applies one item to the machine copy and returns the result it should give
	function automatic tmse_pkg::result_t run_item(tmse_pkg::item_t it);
		tmse_pkg::result_t r;
		tmse_pkg::entry_t e;
		int hit;
		int gap;
		logic [7:0] sym;
		sym = '0;
		case (it.operation)
			tmse_pkg::OP_LOAD: begin
				rule_table[{it.state_index, it.slot_index}] =
					{it.move, it.target_state, it.new_symbol, it.match_symbol};
				rule_loaded[{it.state_index, it.slot_index}] = 1'b1;
			end
			tmse_pkg::OP_WRITE: tape[it.tape_address] = it.tape_symbol;
			tmse_pkg::OP_READ:  sym = tape[it.tape_address];
			default: begin
				// step; does nothing once the machine has stopped
				if (run_state == tmse_pkg::RS_RUN) begin
					if (machine_state == halt_state) begin
						run_state = tmse_pkg::RS_HALT;
					end else begin
						hit = find_rule(gap);
						if (hit < 0) begin
							run_state = tmse_pkg::RS_FAIL;
						end else begin
							e = rule_table[machine_state * SLOTS + hit];
							tape[head_pos] = e.new_symbol;
							machine_state = e.target_state;
							sym = e.new_symbol;
							// off-tape move keeps the head and outranks halting
							if (e.move == tmse_pkg::MV_RIGHT || e.move == tmse_pkg::MV_LEFT) begin
								if (leaves_tape(e.move))
									run_state = tmse_pkg::RS_OFF;
								else if (e.move == tmse_pkg::MV_RIGHT)
									head_pos = head_pos + 10'd1;
								else
									head_pos = head_pos - 10'd1;
							end
							if (run_state == tmse_pkg::RS_RUN && machine_state == halt_state)
								run_state = tmse_pkg::RS_HALT;
						end
					end
				end
			end
		endcase
		r.current_state = machine_state;
		r.head_position = head_pos;
		r.cell_symbol   = sym;
		r.status        = (it.operation == tmse_pkg::OP_LOAD) ? tmse_pkg::ST_LOADED
			: shown_status();
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Item builders
	// ---------------------------------------------------------------

	// All fields random; unused fields of an operation stay random too
	function automatic tmse_pkg::item_t rand_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(tmse_pkg::item_t)-1:0];
	endfunction

	function automatic logic [7:0] pick_sym();
		case ($urandom_range(0, 9))
			0:       return tmse_pkg::BLANK_SYM;
			1:       return SYM_GT;
			2:       return SYM_LT;
			3, 4:    return SYM_ZERO;
			5, 6:    return SYM_ONE;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly a few states so programs revisit them and fill deep slots
	function automatic logic [5:0] pick_state();
		return ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
	endfunction

	function automatic tmse_pkg::item_t rule_item(logic [5:0] st, logic [3:0] sl,
		logic [7:0] m, logic [7:0] n, logic [5:0] t, logic [1:0] mv);
		tmse_pkg::item_t it;
		it = rand_item();
		it.operation    = tmse_pkg::OP_LOAD;
		it.state_index  = st;
		it.slot_index   = sl;
		it.match_symbol = m;
		it.new_symbol   = n;
		it.target_state = t;
		it.move         = mv;
		return it;
	endfunction

	function automatic tmse_pkg::item_t tape_item(logic [1:0] op, logic [9:0] addr,
		logic [7:0] sym);
		tmse_pkg::item_t it;
		it = rand_item();
		it.operation    = op;
		it.tape_address = addr;
		it.tape_symbol  = sym;
		return it;
	endfunction

	function automatic tmse_pkg::item_t step_item();
		tmse_pkg::item_t it;
		it = rand_item();
		it.operation = tmse_pkg::OP_STEP;
		return it;
	endfunction

	// Rule for the current state that neither halts nor runs off the tape
	function automatic tmse_pkg::item_t safe_rule(int slot, logic [7:0] m, logic [7:0] n);
		logic [5:0] t;
		logic [1:0] mv;
		do t = pick_state(); while (t == halt_state);
		mv = 2'($urandom);
		if (leaves_tape(mv))
			mv = tmse_pkg::MV_STAY;
		return rule_item(machine_state, 4'(slot), m, n, t, mv);
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// One item transfer; the expectation is formed at the accepting edge
	task automatic send_item(input tmse_pkg::item_t it);
		if (idle_on && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		expected_results.push_back(run_item(it));
		items_sent++;
	endtask

	// Drop start and wait for every pending result
	task automatic settle();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic queue_reg(input logic [1:0] idx, input logic [9:0] data);
		reg_writes.push_back('{idx, data});
	endtask

	// Register transfers, once every pending result has come back
	task automatic apply_regs();
		reg_write_t w;
		settle();
		cfg_valid <= 1'b1;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_index <= w.index;
			cfg_data  <= w.data;
			do @(posedge clk); while (!cfg_ready);
			case (w.index)
				tmse_pkg::CFG_SYMBOL_COUNT: symbol_count = w.data[4:0];
				tmse_pkg::CFG_HALT_STATE:   halt_state = w.data[5:0];
				tmse_pkg::CFG_HEAD_START: begin
					head_start = w.data;
					head_pos   = w.data;
				end
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Step that keeps the machine running; loads repair rules first when needed
	task automatic send_running_step();
		int hit;
		int gap;
		tmse_pkg::entry_t e;
		bit ok;
		ok = 1'b0;
		while (!ok) begin
			hit = find_rule(gap);
			if (gap >= 0) begin
				send_item(safe_rule(gap, tape[head_pos], pick_sym()));
			end else if (hit < 0) begin
				send_item(safe_rule($urandom_range(0, search_width() - 1), tape[head_pos],
					pick_sym()));
			end else begin
				e = rule_table[machine_state * SLOTS + hit];
				if (e.target_state == halt_state || leaves_tape(e.move))
					send_item(safe_rule(hit, e.match_symbol, e.new_symbol));
				else
					ok = 1'b1;
			end
		end
		send_item(step_item());
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Tape reads and writes at both ends; halt state equal to the current one
	task automatic test_tape_access();
		queue_reg(tmse_pkg::CFG_SYMBOL_COUNT, 10'h3FF);  // 31: wider than the slot list
		queue_reg(tmse_pkg::CFG_HALT_STATE, 10'h3C0);    // state 0: reported halted, not latched
		queue_reg(tmse_pkg::CFG_HEAD_START, 10'h3FF);
		queue_reg(CFG_UNUSED, 10'($urandom));
		apply_regs();
		send_item(tape_item(tmse_pkg::OP_READ, 10'd0, 8'h00));
		send_item(tape_item(tmse_pkg::OP_READ, 10'h3FF, 8'h00));
		send_item(tape_item(tmse_pkg::OP_WRITE, 10'h3FF, 8'hFF));
		send_item(tape_item(tmse_pkg::OP_WRITE, 10'd0, 8'h00));
		send_item(tape_item(tmse_pkg::OP_READ, 10'h3FF, 8'h00));
		send_item(tape_item(tmse_pkg::OP_READ, 10'd0, 8'h00));
	endtask

	// Hand-built program: match past slot 0, right, left, move code three
	task automatic test_directed_steps();
		queue_reg(tmse_pkg::CFG_HALT_STATE, 10'd63);
		queue_reg(tmse_pkg::CFG_HEAD_START, 10'd0);
		apply_regs();
		send_item(rule_item(6'd0, 4'd0, 8'hAA, 8'h00, 6'd0, tmse_pkg::MV_STAY));
		send_item(rule_item(6'd0, 4'd1, 8'h00, 8'hFF, 6'd1, tmse_pkg::MV_RIGHT));
		send_item(step_item());
		send_item(rule_item(6'd1, 4'd0, tmse_pkg::BLANK_SYM, 8'h00, 6'd2, tmse_pkg::MV_LEFT));
		send_item(step_item());
		send_item(rule_item(6'd2, 4'd0, 8'hFF, 8'h5A, 6'd0, MV_HOLD));
		send_item(step_item());
		send_item(rule_item(6'd63, 4'd15, 8'hFF, 8'hFF, 6'd63, tmse_pkg::MV_RIGHT));
		send_item(rule_item(6'd0, 4'd0, 8'h5A, 8'h01, 6'd3, tmse_pkg::MV_STAY));
		send_item(step_item());
		send_item(tape_item(tmse_pkg::OP_READ, 10'd0, 8'h00));
		send_item(tape_item(tmse_pkg::OP_READ, 10'd1, 8'h00));
	endtask

	// Long random programs under several register settings
	task automatic test_random_programs();
		tmse_pkg::item_t it;
		int dice;
		int phase_end;
		logic [4:0] cnt;
		logic [5:0] fin;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0:       cnt = 5'd1;
				1:       cnt = 5'd16;
				2:       cnt = 5'd31;
				default: cnt = 5'($urandom_range(1, 31));
			endcase
			do fin = 6'($urandom); while (fin == machine_state);
			queue_reg(tmse_pkg::CFG_SYMBOL_COUNT, {5'($urandom), cnt});
			queue_reg(tmse_pkg::CFG_HALT_STATE, {4'($urandom), fin});
			queue_reg(tmse_pkg::CFG_HEAD_START, 10'($urandom));
			apply_regs();
			// last phases run without idling
			idle_on  = (p < RANDOM_PHASES - 2);
			idle_pct = $urandom_range(0, 50);
			// repair loads count toward the phase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				it = rand_item();
				dice = $urandom_range(0, 99);
				if (dice < 20) begin
					it.operation    = tmse_pkg::OP_LOAD;
					it.state_index  = pick_state();
					it.match_symbol = pick_sym();
					it.new_symbol   = pick_sym();
					it.target_state = pick_state();
					send_item(it);
				end else if (dice < 50) begin
					it.operation = (dice < 35) ? tmse_pkg::OP_WRITE : tmse_pkg::OP_READ;
					it.tape_symbol = pick_sym();
					if ($urandom_range(0, 1))
						it.tape_address = 10'(int'(head_pos) + $urandom_range(0, 6) - 3);
					send_item(it);
				end else begin
					send_running_step();
				end
			end
		end
	endtask

	// One way of stopping per run, then items against the latched status
	task automatic test_stop_conditions();
		int way;
		logic [1:0] mv;
		idle_on = 1'b0;
		way = $urandom_range(0, 3);
		case (way)
			0: begin
				// a rule into the halt state halts
				send_item(rule_item(machine_state, 4'd0, tape[head_pos], pick_sym(),
					halt_state, tmse_pkg::MV_STAY));
			end
			1: begin
				// stepping while in the halt state only latches halted
				queue_reg(tmse_pkg::CFG_HALT_STATE, {4'b0, machine_state});
				apply_regs();
			end
			2: begin
				// empty search fails
				queue_reg(tmse_pkg::CFG_SYMBOL_COUNT, 10'd0);
				apply_regs();
			end
			default: begin
				// move past a tape end, into the halt state as well
				if ($urandom_range(0, 1)) begin
					queue_reg(tmse_pkg::CFG_HEAD_START, 10'h3FF);
					mv = tmse_pkg::MV_RIGHT;
				end else begin
					queue_reg(tmse_pkg::CFG_HEAD_START, 10'd0);
					mv = tmse_pkg::MV_LEFT;
				end
				apply_regs();
				send_item(rule_item(machine_state, 4'd0, tape[head_pos], pick_sym(),
					halt_state, mv));
			end
		endcase
		repeat (3) send_item(step_item());
		send_item(tape_item(tmse_pkg::OP_READ, head_pos, 8'h00));
		send_item(tape_item(tmse_pkg::OP_WRITE, head_pos, pick_sym()));
		send_item(rule_item(machine_state, 4'd0, tape[head_pos], pick_sym(), 6'd0,
			tmse_pkg::MV_STAY));
		queue_reg(tmse_pkg::CFG_HALT_STATE, {4'b0, 6'(machine_state + 6'd1)});
		apply_regs();
		send_item(step_item());
		send_item(tape_item(tmse_pkg::OP_READ, head_pos, 8'h00));
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		tmse_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no item pending", result));
			end else begin
				want = expected_results.pop_front();
				if (result.current_state !== want.current_state)
					report_mismatch($sformatf("current_state %0d, expected %0d",
						result.current_state, want.current_state));
				if (result.head_position !== want.head_position)
					report_mismatch($sformatf("head_position %0d, expected %0d",
						result.head_position, want.head_position));
				if (result.cell_symbol !== want.cell_symbol)
					report_mismatch($sformatf("cell_symbol %h, expected %h",
						result.cell_symbol, want.cell_symbol));
				if (result.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, want.status));
			end
		end
	end

	// Watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		// machine copy after reset
		foreach (tape[i]) tape[i] = tmse_pkg::BLANK_SYM;
		foreach (rule_loaded[i]) rule_loaded[i] = 1'b0;
		machine_state = '0;
		symbol_count  = tmse_pkg::SYMBOL_COUNT_RST;
		halt_state    = tmse_pkg::HALT_STATE_RST;
		head_start    = tmse_pkg::HEAD_START_RST;
		head_pos      = tmse_pkg::HEAD_START_RST;
		run_state     = tmse_pkg::RS_RUN;
		idle_on       = 1'b1;
		idle_pct      = 30;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_tape_access();
		test_directed_steps();
		test_random_programs();
		test_stop_conditions();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
